// ===== hdl/qalu_pkg.sv =====
package qalu_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRACTION_BITS = 16;

	localparam int PW = 2 * WORD_BITS;
	localparam int VW = 2 * WORD_BITS + 3;
	localparam int SW = 2 * WORD_BITS + 1;
	localparam int RW = WORD_BITS + 1;
	localparam int RMS = WORD_BITS + 4;
	localparam int NB = WORD_BITS + 2 * FRACTION_BITS;
	localparam int DW = SW;
	localparam int RMW = SW + 1;

	localparam int QDEPTH = 2;
	localparam int QAW = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam int LATENCY = 4 + RW + NB;

	localparam logic [3:0] ACT_ADD = 4'd0;
	localparam logic [3:0] ACT_SUB = 4'd1;
	localparam logic [3:0] ACT_MUL = 4'd2;
	localparam logic [3:0] ACT_SCALE = 4'd3;
	localparam logic [3:0] ACT_NEG = 4'd4;
	localparam logic [3:0] ACT_CONJ = 4'd5;
	localparam logic [3:0] ACT_NORMSQ = 4'd6;
	localparam logic [3:0] ACT_NORM = 4'd7;
	localparam logic [3:0] ACT_INVERSE = 4'd8;
	localparam logic [3:0] ACT_NORMALIZE = 4'd9;
	localparam logic [3:0] ACT_EQUAL = 4'd10;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	// Bit 4*i+k is set when term a[k]*b[i^k] is subtracted in lane i of the product.
	localparam logic [15:0] MUL_NEG = 16'b0100_0010_1000_1110;

	localparam logic signed [VW-1:0] LMAX =
		{{(VW - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
	localparam logic signed [VW-1:0] LMIN =
		{{(VW - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};
	localparam logic [VW-1:0] RND_HALF =
		{{(VW - FRACTION_BITS){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

	typedef enum logic [3:0] {
		K_NONE, K_ADD, K_SUB, K_MUL, K_SCALE, K_NEG, K_CONJ,
		K_NSQ, K_NORM, K_INV, K_NRM, K_EQ
	} kind_t;

	typedef logic [WORD_BITS-1:0] lane_t;

	typedef struct packed {
		kind_t kind;
		logic eq;
		lane_t [3:0] a;
		lane_t [3:0] b;
		lane_t f;
	} entry_t;

	typedef struct packed {
		kind_t kind;
		logic eq;
		logic rnd;
		logic [3:0][VW-1:0] val;
		lane_t [3:0] a;
		logic [SW-1:0] s;
		logic [RW-1:0] root;
	} pipe_t;

	function automatic logic [VW-1:0] sxl(input lane_t x);
		return {{(VW - WORD_BITS){x[WORD_BITS-1]}}, x};
	endfunction

endpackage

// ===== hdl/quaternion_alu_unit.sv =====
// Channel   Handshake            Payload
// ------    ---------            -------
// input     start, busy          action, a_w..a_z, b_w..b_z, factor
// result    done (one cycle)     r_w, r_x, r_y, r_z, equal_flag, status
//
// One item is accepted per cycle. Every item, whatever its action, passes the queue, the
// multipliers, the sums, the bit-per-stage square root, the bit-per-stage dividers and
// the rounding stage, in that order; lanes are Q16.16.
// Results leave in the order their items were accepted; the receiver cannot stall them.
// Reset clears the queue and all valid bits; busy stays low in normal operation.
module quaternion_alu_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [3:0] action,
	input  qalu_pkg::lane_t a_w,
	input  qalu_pkg::lane_t a_x,
	input  qalu_pkg::lane_t a_y,
	input  qalu_pkg::lane_t a_z,
	input  qalu_pkg::lane_t b_w,
	input  qalu_pkg::lane_t b_x,
	input  qalu_pkg::lane_t b_y,
	input  qalu_pkg::lane_t b_z,
	input  qalu_pkg::lane_t factor,
	output logic done,
	output qalu_pkg::lane_t r_w,
	output qalu_pkg::lane_t r_x,
	output qalu_pkg::lane_t r_y,
	output qalu_pkg::lane_t r_z,
	output logic equal_flag,
	output logic [1:0] status
);

	qalu_pkg::entry_t front_entry;
	qalu_pkg::entry_t queue_head;
	logic q_full;
	logic q_empty;
	logic push;
	logic pop;

	assign busy = q_full;
	assign push = start && !busy;
	assign pop = !q_empty;

	qalu_front u_front (
		.action(action),
		.a_w(a_w),
		.a_x(a_x),
		.a_y(a_y),
		.a_z(a_z),
		.b_w(b_w),
		.b_x(b_x),
		.b_y(b_y),
		.b_z(b_z),
		.factor(factor),
		.entry(front_entry)
	);

	qalu_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.wdata(front_entry),
		.rdata(queue_head),
		.full(q_full),
		.empty(q_empty)
	);

	qalu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pop),
		.in_entry(queue_head),
		.done(done),
		.r_w(r_w),
		.r_x(r_x),
		.r_y(r_y),
		.r_z(r_z),
		.equal_flag(equal_flag),
		.status(status)
	);

endmodule

// ===== hdl/qalu_front.sv =====
module qalu_front (
	input  logic [3:0] action,
	input  qalu_pkg::lane_t a_w,
	input  qalu_pkg::lane_t a_x,
	input  qalu_pkg::lane_t a_y,
	input  qalu_pkg::lane_t a_z,
	input  qalu_pkg::lane_t b_w,
	input  qalu_pkg::lane_t b_x,
	input  qalu_pkg::lane_t b_y,
	input  qalu_pkg::lane_t b_z,
	input  qalu_pkg::lane_t factor,
	output qalu_pkg::entry_t entry
);

	qalu_pkg::kind_t kind;

	always_comb begin
		case (action)
			qalu_pkg::ACT_ADD: kind = qalu_pkg::K_ADD;
			qalu_pkg::ACT_SUB: kind = qalu_pkg::K_SUB;
			qalu_pkg::ACT_MUL: kind = qalu_pkg::K_MUL;
			qalu_pkg::ACT_SCALE: kind = qalu_pkg::K_SCALE;
			qalu_pkg::ACT_NEG: kind = qalu_pkg::K_NEG;
			qalu_pkg::ACT_CONJ: kind = qalu_pkg::K_CONJ;
			qalu_pkg::ACT_NORMSQ: kind = qalu_pkg::K_NSQ;
			qalu_pkg::ACT_NORM: kind = qalu_pkg::K_NORM;
			qalu_pkg::ACT_INVERSE: kind = qalu_pkg::K_INV;
			qalu_pkg::ACT_NORMALIZE: kind = qalu_pkg::K_NRM;
			qalu_pkg::ACT_EQUAL: kind = qalu_pkg::K_EQ;
			default: kind = qalu_pkg::K_NONE;
		endcase
	end

	always_comb begin
		entry.kind = kind;
		entry.eq = (kind == qalu_pkg::K_EQ) && (a_w == b_w) && (a_x == b_x)
			&& (a_y == b_y) && (a_z == b_z);
		entry.a = {a_z, a_y, a_x, a_w};
		entry.b = {b_z, b_y, b_x, b_w};
		entry.f = factor;
	end

endmodule

// ===== hdl/qalu_fifo.sv =====
module qalu_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic pop,
	input  qalu_pkg::entry_t wdata,
	output qalu_pkg::entry_t rdata,
	output logic full,
	output logic empty
);

	qalu_pkg::entry_t mem_q [qalu_pkg::QDEPTH];
	logic [qalu_pkg::QAW-1:0] wr_ptr_q;
	logic [qalu_pkg::QAW-1:0] rd_ptr_q;
	logic [qalu_pkg::QCW-1:0] count_q;

	assign full = (count_q == qalu_pkg::QCW'(qalu_pkg::QDEPTH));
	assign empty = (count_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == qalu_pkg::QAW'(qalu_pkg::QDEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == qalu_pkg::QAW'(qalu_pkg::QDEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			count_q <= count_q + qalu_pkg::QCW'(push) - qalu_pkg::QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== hdl/qalu_back.sv =====
module qalu_back (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  qalu_pkg::entry_t in_entry,
	output logic done,
	output qalu_pkg::lane_t r_w,
	output qalu_pkg::lane_t r_x,
	output qalu_pkg::lane_t r_y,
	output qalu_pkg::lane_t r_z,
	output logic equal_flag,
	output logic [1:0] status
);

	localparam int W = qalu_pkg::WORD_BITS;
	localparam int F = qalu_pkg::FRACTION_BITS;
	localparam int PW = qalu_pkg::PW;
	localparam int VW = qalu_pkg::VW;
	localparam int SW = qalu_pkg::SW;
	localparam int RW = qalu_pkg::RW;
	localparam int RMS = qalu_pkg::RMS;
	localparam int NB = qalu_pkg::NB;
	localparam int DW = qalu_pkg::DW;
	localparam int RMW = qalu_pkg::RMW;

	// Stage 1: sixteen lane multipliers.
	logic [PW-1:0] prod_c [4][4];
	logic [PW-1:0] prod_s1 [4][4];
	qalu_pkg::entry_t ent_s1;
	logic v_s1;

	always_comb begin
		qalu_pkg::lane_t opnd;
		logic signed [PW-1:0] ea;
		logic signed [PW-1:0] eb;
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 4; k++) begin
				if (k == i) begin
					case (in_entry.kind)
						qalu_pkg::K_MUL: opnd = in_entry.b[0];
						qalu_pkg::K_SCALE: opnd = in_entry.f;
						default: opnd = in_entry.a[i];
					endcase
				end else begin
					opnd = in_entry.b[i ^ k];
				end
				ea = {{W{in_entry.a[k][W-1]}}, in_entry.a[k]};
				eb = {{W{opnd[W-1]}}, opnd};
				prod_c[i][k] = ea * eb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ent_s1 <= in_entry;
		prod_s1 <= prod_c;
	end

	// Stage 2: sums, the squared norm and the linear operations.
	qalu_pkg::pipe_t pl_c2;
	qalu_pkg::pipe_t pl_s2;
	logic v_s2;

	always_comb begin
		logic [SW-1:0] ssum;
		logic [VW-1:0] acc;
		logic [VW-1:0] pk;
		logic [VW-1:0] sa;
		logic [VW-1:0] sb;
		ssum = '0;
		for (int i = 0; i < 4; i++) begin
			ssum = ssum + SW'(prod_s1[i][i]);
		end
		pl_c2.kind = ent_s1.kind;
		pl_c2.eq = ent_s1.eq;
		pl_c2.rnd = (ent_s1.kind == qalu_pkg::K_MUL) || (ent_s1.kind == qalu_pkg::K_SCALE)
			|| (ent_s1.kind == qalu_pkg::K_NSQ);
		pl_c2.a = ent_s1.a;
		pl_c2.s = ssum;
		pl_c2.root = '0;
		for (int i = 0; i < 4; i++) begin
			acc = '0;
			for (int k = 0; k < 4; k++) begin
				pk = {{(VW - PW){prod_s1[i][k][PW-1]}}, prod_s1[i][k]};
				acc = qalu_pkg::MUL_NEG[i*4+k] ? acc - pk : acc + pk;
			end
			sa = qalu_pkg::sxl(ent_s1.a[i]);
			sb = qalu_pkg::sxl(ent_s1.b[i]);
			pk = {{(VW - PW){prod_s1[i][i][PW-1]}}, prod_s1[i][i]};
			case (ent_s1.kind)
				qalu_pkg::K_ADD: pl_c2.val[i] = sa + sb;
				qalu_pkg::K_SUB: pl_c2.val[i] = sa - sb;
				qalu_pkg::K_MUL: pl_c2.val[i] = acc;
				qalu_pkg::K_SCALE: pl_c2.val[i] = pk;
				qalu_pkg::K_NEG: pl_c2.val[i] = '0 - sa;
				qalu_pkg::K_CONJ: pl_c2.val[i] = (i == 0) ? sa : '0 - sa;
				qalu_pkg::K_NSQ: pl_c2.val[i] = (i == 0) ? VW'(ssum) : '0;
				default: pl_c2.val[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		pl_s2 <= pl_c2;
	end

	// Stage group 3: square root, one result bit per stage.
	qalu_pkg::pipe_t sq_pl_s3 [RW];
	logic [RMS-1:0] sq_rem_s3 [RW];
	logic [RW-1:0] sq_root_s3 [RW];
	logic sq_v_s3 [RW];
	logic [RMS-1:0] sq_rem_d [RW];
	logic [RW-1:0] sq_root_d [RW];

	always_comb begin
		logic [RMS-1:0] rc;
		logic [RMS-1:0] rn;
		logic [RMS-1:0] tr;
		logic [RW-1:0] oc;
		logic [2*RW-1:0] sp;
		for (int j = 0; j < RW; j++) begin
			if (j == 0) begin
				rc = '0;
				oc = '0;
				sp = {1'b0, pl_s2.s};
			end else begin
				rc = sq_rem_s3[j-1];
				oc = sq_root_s3[j-1];
				sp = {1'b0, sq_pl_s3[j-1].s};
			end
			rn = {rc[RMS-3:0], sp[2*(RW-1-j) +: 2]};
			tr = RMS'({oc, 2'b01});
			if (rn >= tr) begin
				sq_rem_d[j] = rn - tr;
				sq_root_d[j] = {oc[RW-2:0], 1'b1};
			end else begin
				sq_rem_d[j] = rn;
				sq_root_d[j] = {oc[RW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < RW; j++) begin
				sq_v_s3[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < RW; j++) begin
				sq_v_s3[j] <= (j == 0) ? v_s2 : sq_v_s3[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < RW; j++) begin
			sq_pl_s3[j] <= (j == 0) ? pl_s2 : sq_pl_s3[j-1];
			sq_rem_s3[j] <= sq_rem_d[j];
			sq_root_s3[j] <= sq_root_d[j];
		end
	end

	// Stage group 4: four restoring dividers, one quotient bit per stage.
	qalu_pkg::pipe_t pl_d0;
	logic [DW-1:0] d_d0;
	logic [3:0][NB-1:0] n_d0;

	always_comb begin
		qalu_pkg::lane_t ab;
		pl_d0 = sq_pl_s3[RW-1];
		pl_d0.root = sq_root_s3[RW-1];
		d_d0 = (pl_d0.kind == qalu_pkg::K_INV) ? pl_d0.s : DW'(sq_root_s3[RW-1]);
		for (int i = 0; i < 4; i++) begin
			ab = pl_d0.a[i][W-1] ? (~pl_d0.a[i] + 1'b1) : pl_d0.a[i];
			n_d0[i] = (pl_d0.kind == qalu_pkg::K_INV) ? {ab, {(2*F){1'b0}}}
				: NB'({ab, {F{1'b0}}});
		end
	end

	qalu_pkg::pipe_t dv_pl_s4 [NB];
	logic [DW-1:0] dv_d_s4 [NB];
	logic [3:0][NB-1:0] dv_n_s4 [NB];
	logic [3:0][RMW-1:0] dv_rem_s4 [NB];
	logic [3:0][NB-1:0] dv_q_s4 [NB];
	logic dv_v_s4 [NB];
	logic [3:0][RMW-1:0] dv_rem_d [NB];
	logic [3:0][NB-1:0] dv_q_d [NB];

	always_comb begin
		logic [RMW-1:0] rc;
		logic [RMW-1:0] rn;
		logic [NB-1:0] qc;
		logic [NB-1:0] nc;
		logic [DW-1:0] dc;
		for (int j = 0; j < NB; j++) begin
			for (int i = 0; i < 4; i++) begin
				if (j == 0) begin
					rc = '0;
					qc = '0;
					nc = n_d0[i];
					dc = d_d0;
				end else begin
					rc = dv_rem_s4[j-1][i];
					qc = dv_q_s4[j-1][i];
					nc = dv_n_s4[j-1][i];
					dc = dv_d_s4[j-1];
				end
				rn = {rc[RMW-2:0], nc[NB-1-j]};
				if (rn >= {1'b0, dc}) begin
					dv_rem_d[j][i] = rn - {1'b0, dc};
					dv_q_d[j][i] = {qc[NB-2:0], 1'b1};
				end else begin
					dv_rem_d[j][i] = rn;
					dv_q_d[j][i] = {qc[NB-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NB; j++) begin
				dv_v_s4[j] <= 1'b0;
			end
		end else begin
			for (int j = 0; j < NB; j++) begin
				dv_v_s4[j] <= (j == 0) ? sq_v_s3[RW-1] : dv_v_s4[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NB; j++) begin
			dv_pl_s4[j] <= (j == 0) ? pl_d0 : dv_pl_s4[j-1];
			dv_d_s4[j] <= (j == 0) ? d_d0 : dv_d_s4[j-1];
			dv_n_s4[j] <= (j == 0) ? n_d0 : dv_n_s4[j-1];
			dv_rem_s4[j] <= dv_rem_d[j];
			dv_q_s4[j] <= dv_q_d[j];
		end
	end

	// Stage 5: rounding, sign, saturation and status.
	qalu_pkg::pipe_t pl_f;
	qalu_pkg::lane_t [3:0] lane_c;
	logic sat_c;
	logic zero_c;

	assign pl_f = dv_pl_s4[NB-1];

	always_comb begin
		logic [VW-1:0] v;
		logic [VW-1:0] qv;
		logic [VW-1:0] tmp;
		logic neg;
		sat_c = 1'b0;
		zero_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if ((pl_f.kind == qalu_pkg::K_INV) && (i != 0)) begin
				neg = !pl_f.a[i][W-1] && (pl_f.a[i] != '0);
			end else begin
				neg = pl_f.a[i][W-1];
			end
			qv = {{(VW - NB){1'b0}}, dv_q_s4[NB-1][i]};
			tmp = pl_f.val[i] + qalu_pkg::RND_HALF;
			case (pl_f.kind)
				qalu_pkg::K_MUL, qalu_pkg::K_SCALE, qalu_pkg::K_NSQ: begin
					v = VW'($signed(tmp) >>> F);
				end
				qalu_pkg::K_NORM: begin
					v = (i == 0) ? VW'(pl_f.root) : '0;
				end
				qalu_pkg::K_INV, qalu_pkg::K_NRM: begin
					if (pl_f.s == '0) begin
						v = '0;
						zero_c = 1'b1;
					end else begin
						v = neg ? '0 - qv : qv;
					end
				end
				default: begin
					v = pl_f.val[i];
				end
			endcase
			if ($signed(v) > qalu_pkg::LMAX) begin
				lane_c[i] = qalu_pkg::LMAX[W-1:0];
				sat_c = 1'b1;
			end else if ($signed(v) < qalu_pkg::LMIN) begin
				lane_c[i] = qalu_pkg::LMIN[W-1:0];
				sat_c = 1'b1;
			end else begin
				lane_c[i] = v[W-1:0];
			end
		end
	end

	qalu_pkg::lane_t [3:0] lane_s5;
	logic eq_s5;
	logic [1:0] status_s5;
	logic done_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= dv_v_s4[NB-1];
		end
	end

	always_ff @(posedge clk) begin
		lane_s5 <= lane_c;
		eq_s5 <= (pl_f.kind == qalu_pkg::K_EQ) && pl_f.eq;
		status_s5 <= sat_c ? qalu_pkg::ST_SAT : (zero_c ? qalu_pkg::ST_ZERO : qalu_pkg::ST_OK);
	end

	assign done = done_s5;
	assign r_w = lane_s5[0];
	assign r_x = lane_s5[1];
	assign r_y = lane_s5[2];
	assign r_z = lane_s5[3];
	assign equal_flag = eq_s5;
	assign status = status_s5;

endmodule

// ===== hdl/qalu_checker.sv =====
module qalu_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input qalu_pkg::lane_t r_w,
	input qalu_pkg::lane_t r_x,
	input qalu_pkg::lane_t r_y,
	input qalu_pkg::lane_t r_z,
	input logic equal_flag,
	input logic [1:0] status
);

	// The back end drains the queue every cycle, so it never fills.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("queue filled up");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(qalu_pkg::LATENCY) done)
		else $error("result missing at fixed latency");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == qalu_pkg::ST_OK || status == qalu_pkg::ST_ZERO
			|| status == qalu_pkg::ST_SAT))
		else $error("undefined status code");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == qalu_pkg::ST_ZERO) |->
		(r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0 && !equal_flag))
		else $error("zero-norm result not zero");

	a_equal_result: assert property (@(posedge clk) disable iff (!arst_n)
		(done && equal_flag) |->
		(status == qalu_pkg::ST_OK && r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0))
		else $error("equality result carries data");

endmodule

bind quaternion_alu_unit qalu_checker u_qalu_checker (.*);
